// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("check failed");
`endif

// File: hw/rtl/cdibl_pkg.sv
// Package with types and codes of the block list.
`default_nettype none
package cdibl_pkg;
    localparam logic [2:0] EV_ADDED    = 3'd0;
    localparam logic [2:0] EV_REJECTED = 3'd1;
    localparam logic [2:0] EV_REMOVED  = 3'd2;
    localparam logic [2:0] EV_NOTLIST  = 3'd3;
    localparam logic [2:0] EV_EMPTY    = 3'd4;
    localparam logic [2:0] EV_HEADER   = 3'd5;
    localparam logic [2:0] EV_ENTRY    = 3'd6;
    localparam logic [2:0] EV_QUERY    = 3'd7;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_BLOCK   = 2'd1;
    localparam logic [1:0] CMD_UNBLOCK = 2'd2;
    localparam logic [1:0] CMD_LIST    = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_byte;
        logic [7:0] id_high;
        logic [7:0] id_low;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] entry_index;
        logic [7:0] res_id_high;
        logic [7:0] res_id_low;
        logic [4:0] entry_total;
        logic       is_blocked;
        logic       last;
    } t_out_item;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load_in;
        logic store_char;
        logic clr_line;
        logic scan_clr;
        logic scan_step;
        logic tab_clr;
        logic tab_step;
        logic do_add;
        logic shift_step;
        logic dec_count;
        logic emit;
        logic [2:0] emit_ev;
        logic emit_last;
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic       is_query;
        logic       is_eol;
        logic       line_empty;
        logic       line_full;
        logic       scan_done;
        logic [1:0] cmd_kind;
        logic       id_ok;
        logic       tab_done;
        logic       hit;
        logic       full;
        logic       count_zero;
        logic       shift_done;
        logic       list_last;
        logic       out_busy;
    } t_sts;

    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/cdibl_if.sv
// Valid/ready channel interface carrying one item.
`default_nettype none
interface cdibl_if #(parameter int W = 8) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cdibl_datapath.sv
// Datapath: line memory, command scanner, id table and output register.
`default_nettype none
module cdibl_datapath
    import cdibl_pkg::*;
#(
    parameter int MAX_BLOCKED = 16,
    parameter int LINE_LEN = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    output t_sts           o_sts,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);
    localparam int LW = $clog2(LINE_LEN) + 1;
    localparam int IW = $clog2(LINE_LEN - 1);
    localparam int TW = $clog2(MAX_BLOCKED + 1);
    localparam int AW = (MAX_BLOCKED > 1) ? $clog2(MAX_BLOCKED) : 1;

    logic [7:0]    r_line [LINE_LEN-1];
    logic [15:0]   r_tab [MAX_BLOCKED];
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_sidx;
    logic [TW-1:0] r_cnt;
    logic [TW-1:0] r_tidx;
    t_in_item      r_in;
    logic [7:0]    r_rd;
    logic          r_rd_ok;
    logic          r_zero_seen;
    logic [LW-1:0] r_n;
    logic [1:0]    w_kind;
    logic          r_bad_b;
    logic          r_bad_u;
    logic          r_bad_l;
    logic [15:0]   r_id;
    logic [15:0]   r_pid_b;
    logic [15:0]   r_pid_u;
    logic          r_hex_b;
    logic          r_hex_u;
    logic          r_hit;
    logic [TW-1:0] r_pos;
    logic          r_ov;
    t_out_item     r_out;

    logic [15:0] w_key;
    logic [15:0] w_tab_rd;
    logic [7:0]  w_exp_b;
    logic [7:0]  w_exp_u;
    logic [7:0]  w_exp_l;
    logic [4:0]  w_nib;
    logic [LW-1:0] w_p;

    assign w_key = r_in.operation ? {r_in.id_high, r_in.id_low} : r_id;
    assign w_tab_rd = r_tab[r_tidx[AW-1:0]];
    assign w_p = r_sidx - LW'(1);
    assign w_nib = hex_nib(r_rd);

    always_comb begin
        case (w_p)
            LW'(0): w_exp_b = 8'h62;
            LW'(1): w_exp_b = 8'h6c;
            LW'(2): w_exp_b = 8'h6f;
            LW'(3): w_exp_b = 8'h63;
            LW'(4): w_exp_b = 8'h6b;
            LW'(5): w_exp_b = 8'h20;
            default: w_exp_b = 8'h00;
        endcase
        case (w_p)
            LW'(0): w_exp_u = 8'h75;
            LW'(1): w_exp_u = 8'h6e;
            LW'(2): w_exp_u = 8'h62;
            LW'(3): w_exp_u = 8'h6c;
            LW'(4): w_exp_u = 8'h6f;
            LW'(5): w_exp_u = 8'h63;
            LW'(6): w_exp_u = 8'h6b;
            LW'(7): w_exp_u = 8'h20;
            default: w_exp_u = 8'h00;
        endcase
        case (w_p)
            LW'(0): w_exp_l = 8'h6c;
            LW'(1): w_exp_l = 8'h69;
            LW'(2): w_exp_l = 8'h73;
            LW'(3): w_exp_l = 8'h74;
            default: w_exp_l = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_item;
        if (i_cmd.store_char) r_line[r_len[IW-1:0]] <= r_in.char_byte;
        if (i_cmd.scan_clr) r_rd <= r_line[0];
        else if (i_cmd.scan_step && r_sidx < r_len) r_rd <= r_line[r_sidx[IW-1:0]];
        if (i_cmd.do_add) r_tab[r_cnt[AW-1:0]] <= r_id;
        if (i_cmd.shift_step) r_tab[r_pos[AW-1:0]] <= r_tab[AW'(r_pos + TW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_sidx <= '0;
            r_tidx <= '0;
            r_rd_ok <= 1'b0;
            r_zero_seen <= 1'b0;
            r_n <= '0;
            r_bad_b <= 1'b0;
            r_bad_u <= 1'b0;
            r_bad_l <= 1'b0;
            r_hex_b <= 1'b0;
            r_hex_u <= 1'b0;
            r_hit <= 1'b0;
            r_pos <= '0;
        end else begin
            if (i_cmd.store_char) r_len <= r_len + LW'(1);
            if (i_cmd.clr_line) r_len <= '0;
            if (i_cmd.scan_clr) begin
                r_sidx <= LW'(1);
                r_rd_ok <= 1'b1;
                r_zero_seen <= 1'b0;
                r_n <= '0;
                r_bad_b <= 1'b0;
                r_bad_u <= 1'b0;
                r_bad_l <= 1'b0;
                r_hex_b <= 1'b1;
                r_hex_u <= 1'b1;
            end else if (i_cmd.scan_step) begin
                r_sidx <= r_sidx + LW'(1);
                r_rd_ok <= (r_sidx < r_len);
                if (r_rd_ok && !r_zero_seen && r_rd != 8'h00) begin
                    r_n <= r_n + LW'(1);
                    if (w_p < LW'(6) && r_rd != w_exp_b) r_bad_b <= 1'b1;
                    if (w_p < LW'(8) && r_rd != w_exp_u) r_bad_u <= 1'b1;
                    if (w_p < LW'(4) && r_rd != w_exp_l) r_bad_l <= 1'b1;
                    if (w_p >= LW'(6) && w_p < LW'(10)) begin
                        if (w_nib[4]) r_hex_b <= 1'b0;
                        r_pid_b <= {r_pid_b[11:0], w_nib[3:0]};
                    end
                    if (w_p >= LW'(8) && w_p < LW'(12)) begin
                        if (w_nib[4]) r_hex_u <= 1'b0;
                        r_pid_u <= {r_pid_u[11:0], w_nib[3:0]};
                    end
                end else if (r_rd_ok) begin
                    r_zero_seen <= 1'b1;
                end
            end
            if (i_cmd.tab_clr) begin
                r_tidx <= '0;
                r_hit <= 1'b0;
                r_pos <= '0;
                r_id <= (w_kind == CMD_UNBLOCK) ? r_pid_u : r_pid_b;
            end else if (i_cmd.tab_step) begin
                r_tidx <= r_tidx + TW'(1);
                if (!r_hit && w_tab_rd == w_key) begin
                    r_hit <= 1'b1;
                    r_pos <= r_tidx;
                end
            end else if (i_cmd.shift_step) begin
                r_pos <= r_pos + TW'(1);
            end
            if (i_cmd.do_add) r_cnt <= r_cnt + TW'(1);
            if (i_cmd.dec_count) r_cnt <= r_cnt - TW'(1);
            if (i_cmd.emit) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_comb begin
        w_kind = CMD_NONE;
        if (!r_bad_b && r_n >= LW'(6)) w_kind = CMD_BLOCK;
        else if (!r_bad_u && r_n >= LW'(8)) w_kind = CMD_UNBLOCK;
        else if (!r_bad_l && r_n == LW'(4)) w_kind = CMD_LIST;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.event_res <= i_cmd.emit_ev;
            r_out.last <= i_cmd.emit_last;
            r_out.entry_index <= '0;
            r_out.res_id_high <= '0;
            r_out.res_id_low <= '0;
            r_out.entry_total <= '0;
            r_out.is_blocked <= 1'b0;
            case (i_cmd.emit_ev)
                EV_QUERY: begin
                    r_out.res_id_high <= r_in.id_high;
                    r_out.res_id_low <= r_in.id_low;
                    r_out.is_blocked <= r_hit;
                end
                EV_HEADER: r_out.entry_total <= 5'(r_cnt);
                EV_ENTRY: begin
                    r_out.entry_index <= 4'(r_tidx);
                    r_out.res_id_high <= w_tab_rd[15:8];
                    r_out.res_id_low <= w_tab_rd[7:0];
                end
                EV_EMPTY: ;
                default: begin
                    r_out.res_id_high <= r_id[15:8];
                    r_out.res_id_low <= r_id[7:0];
                end
            endcase
        end
    end

    always_comb begin
        o_sts.is_query   = r_in.operation;
        o_sts.is_eol     = (r_in.char_byte == CH_LF) || (r_in.char_byte == CH_CR);
        o_sts.line_empty = (r_len == '0);
        o_sts.line_full  = (r_len == LW'(LINE_LEN - 1));
        o_sts.scan_done  = (r_sidx > r_len);
        o_sts.cmd_kind   = w_kind;
        o_sts.id_ok      = (w_kind == CMD_BLOCK) ? (r_hex_b && r_n >= LW'(10))
                                                 : (r_hex_u && r_n >= LW'(12));
        o_sts.tab_done   = (r_tidx >= r_cnt);
        o_sts.hit        = r_hit;
        o_sts.full       = (r_cnt >= TW'(MAX_BLOCKED));
        o_sts.count_zero = (r_cnt == '0);
        o_sts.shift_done = (r_pos + TW'(1) >= r_cnt);
        o_sts.list_last  = (r_tidx + TW'(1) >= r_cnt);
        o_sts.out_busy   = r_ov && !i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule
`default_nettype wire

// File: hw/rtl/cdibl_ctrl.sv
// Controller state machine sequencing item handling.
`default_nettype none
module cdibl_ctrl
    import cdibl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DEC    = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_CLASS  = 10'b0000001000,
        S_FIND   = 10'b0000010000,
        S_RES    = 10'b0000100000,
        S_SHIFT  = 10'b0001000000,
        S_HEAD   = 10'b0010000000,
        S_LIST   = 10'b0100000000,
        S_QRES   = 10'b1000000000
    } t_state;

    t_state r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else r_st <= n_st;
    end

    always_comb begin
        o_cmd = '0;
        n_st = r_st;
        o_in_ready = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_cmd.load_in = 1'b1;
                    n_st = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_query) begin
                    o_cmd.tab_clr = 1'b1;
                    n_st = S_FIND;
                end else if (!i_sts.is_eol) begin
                    o_cmd.store_char = !i_sts.line_full;
                    n_st = S_IDLE;
                end else if (i_sts.line_empty) begin
                    n_st = S_IDLE;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_st = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_st = S_CLASS;
            end
            S_CLASS: begin
                o_cmd.clr_line = 1'b1;
                unique case (i_sts.cmd_kind)
                    CMD_BLOCK, CMD_UNBLOCK: begin
                        if (i_sts.id_ok) begin
                            o_cmd.tab_clr = 1'b1;
                            n_st = S_FIND;
                        end else n_st = S_IDLE;
                    end
                    CMD_LIST: begin
                        o_cmd.tab_clr = 1'b1;
                        n_st = S_HEAD;
                    end
                    default: n_st = S_IDLE;
                endcase
            end
            S_FIND: begin
                if (i_sts.tab_done || i_sts.hit) begin
                    n_st = i_sts.is_query ? S_QRES : S_RES;
                end else o_cmd.tab_step = 1'b1;
            end
            S_QRES: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_ev = EV_QUERY;
                    o_cmd.emit_last = 1'b1;
                    n_st = S_IDLE;
                end
            end
            S_RES: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_st = S_IDLE;
                    if (i_sts.cmd_kind == CMD_BLOCK) begin
                        if (!i_sts.hit && !i_sts.full) begin
                            o_cmd.emit_ev = EV_ADDED;
                            o_cmd.do_add = 1'b1;
                        end else o_cmd.emit_ev = EV_REJECTED;
                    end else if (i_sts.hit) begin
                        o_cmd.emit_ev = EV_REMOVED;
                        n_st = S_SHIFT;
                    end else o_cmd.emit_ev = EV_NOTLIST;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    o_cmd.dec_count = 1'b1;
                    n_st = S_IDLE;
                end else o_cmd.shift_step = 1'b1;
            end
            S_HEAD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.count_zero) begin
                        o_cmd.emit_ev = EV_EMPTY;
                        o_cmd.emit_last = 1'b1;
                        n_st = S_IDLE;
                    end else begin
                        o_cmd.emit_ev = EV_HEADER;
                        n_st = S_LIST;
                    end
                end
            end
            S_LIST: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_ev = EV_ENTRY;
                    o_cmd.emit_last = i_sts.list_last;
                    o_cmd.tab_step = 1'b1;
                    if (i_sts.list_last) n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/command_driven_id_block_list_top.sv
// Top level of the command driven node-id block list.
// Channel | Dir | Payload
// in_ch   | in  | operation, char_byte, id_high, id_low
// out_ch  | out | event_res, entry_index, res_id_high, res_id_low, entry_total,
//         |     | is_blocked, last
// A line end starts a scan and classification of the stored line, then, for block or unblock, a
// sequential table search, a result on the output and, after a removal, a shift of the table.
// A query runs the sequential table search and then gives its result.
// Reset is synchronous and active low and empties the line and the table.
// A stalled output holds its result; no result or item is taken while it waits.
`default_nettype none
module command_driven_id_block_list_top
    import cdibl_pkg::*;
#(
    parameter int MAX_BLOCKED = 16,
    parameter int LINE_LEN = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cdibl_if.sink     in_ch,
    cdibl_if.source   out_ch
);
    t_cmd      w_cmd;
    t_sts      w_sts;
    t_out_item w_out;

    cdibl_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    cdibl_datapath #(.MAX_BLOCKED(MAX_BLOCKED), .LINE_LEN(LINE_LEN)) u_dp (
        .i_clk, .i_rst_n,
        .i_item(t_in_item'(in_ch.data)), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .o_out(w_out)
    );

    assign out_ch.data = w_out;
endmodule
`default_nettype wire

// File: hw/rtl/cdibl_checker.sv
// Port-level checker for the block list, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cdibl_checker
    import cdibl_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [29:0] i_out_data
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    `CHK_IMPL(a_no_take_busy, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
    `CHK_IMPL(a_query_idx, i_clk, i_rst_n, i_out_valid && i_out_data[29:27] == EV_QUERY, i_out_data[0] && i_out_data[26:23] == 4'd0)
    `CHK_IMPL(a_hdr_notlast, i_clk, i_rst_n, i_out_valid && i_out_data[29:27] == EV_HEADER, !i_out_data[0] && i_out_data[6:2] != 5'd0)
endmodule
bind command_driven_id_block_list_top cdibl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_out_data(out_ch.data)
);
`default_nettype wire
